/* src/ksc_pkg.sv */
// Shared types and constants for the keyword substitution cipher core.
// Holds the alphabet geometry, the item kind codes, the sequencer states
// and the control struct that the sequencer sends to the key store and map table.
package ksc_pkg;

  localparam int ALPHA_N = 26;
  localparam int IDX_W   = (ALPHA_N > 1) ? $clog2(ALPHA_N) : 1;
  localparam int CNT_W   = $clog2(ALPHA_N + 1);

  localparam logic [7:0] LETTER_BASE = 8'h61;
  localparam logic [7:0] LETTER_LAST = 8'(32'h61 + ALPHA_N - 1);

  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_END = 2'd1,
    KIND_ENC = 2'd2,
    KIND_DEC = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_COPY
  } state_t;

  typedef struct packed {
    logic             key_letter;
    logic             letter_ok;
    logic [IDX_W-1:0] letter_idx;
    logic             fill_step;
    logic             copy_step;
    logic             clear;
    logic [IDX_W-1:0] walk_idx;
  } ksc_ctl_t;

endpackage

/* src/keyword_substitution_cipher_core.sv */
// Keyword substitution cipher core. Key letters, encrypt bytes and decrypt bytes each
// answer in the cycle after acceptance: the result is registered and, while the core is
// idle, the next transaction is accepted as soon as the output register is free or being
// emptied. An end-of-key transaction that installs a key runs the sequencer over the
// alphabet twice, once to append unused letters and once to load the forward and inverse
// tables, before its result appears; a rejected key answers in the cycle after acceptance.
// Depends on ksc_pkg, ksc_key_store and ksc_map_table.
module keyword_substitution_cipher_core
  import ksc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_status
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic out_status_r, out_status_nxt;
  logic load;
  logic accept, walk_last, is_letter, reject;
  logic [IDX_W-1:0] letter_idx, look_map, pend_rd;
  logic [CNT_W-1:0] pend_cnt;
  logic key_bad;
  kind_t kind;
  ksc_ctl_t ctl;

  assign kind       = kind_t'(in_kind);
  assign accept     = in_valid && in_ready;
  assign walk_last  = (walk_r == IDX_W'(ALPHA_N - 1));
  assign is_letter  = (in_value >= LETTER_BASE) && (in_value <= LETTER_LAST);
  assign letter_idx = IDX_W'(in_value - LETTER_BASE);
  assign reject     = key_bad || (pend_cnt == '0);

  ksc_key_store u_key_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .pend_rd  (pend_rd),
    .pend_cnt (pend_cnt),
    .key_bad  (key_bad)
  );

  ksc_map_table u_map_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .pend_rd  (pend_rd),
    .look_idx (letter_idx),
    .look_inv (kind == KIND_DEC),
    .look_map (look_map)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && kind == KIND_END && !reject) state_nxt = S_FILL;
      end
      S_FILL: begin
        if (walk_last) state_nxt = S_COPY;
      end
      S_COPY: begin
        if (walk_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl            = '0;
    ctl.letter_ok  = is_letter;
    ctl.letter_idx = letter_idx;
    ctl.walk_idx   = walk_r;
    in_ready       = 1'b0;
    walk_nxt       = walk_r;
    load           = 1'b0;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        walk_nxt = '0;
        if (accept) begin
          out_char_nxt   = 8'h00;
          out_status_nxt = 1'b0;
          unique case (kind)
            KIND_KEY: begin
              ctl.key_letter = 1'b1;
              load = 1'b1;
            end
            KIND_END: begin
              if (reject) begin
                ctl.clear      = 1'b1;
                out_status_nxt = 1'b1;
                load           = 1'b1;
              end
            end
            KIND_ENC, KIND_DEC: begin
              load         = 1'b1;
              out_char_nxt = is_letter ? (LETTER_BASE + 8'(look_map)) : in_value;
            end
            default: load = 1'b0;
          endcase
        end
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        walk_nxt = walk_last ? '0 : walk_r + IDX_W'(1);
      end
      S_COPY: begin
        ctl.copy_step = 1'b1;
        walk_nxt = walk_last ? '0 : walk_r + IDX_W'(1);
        if (walk_last) begin
          ctl.clear      = 1'b1;
          load           = 1'b1;
          out_char_nxt   = 8'h00;
          out_status_nxt = 1'b0;
        end
      end
      default: walk_nxt = '0;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_status = out_status_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("input accepted while a key is being installed");

  a_fill_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> !out_valid_r)
    else $error("result pending during key installation");

  a_install_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && walk_last) |=> (out_valid_r && !out_status_r && state_r == S_IDLE))
    else $error("installed key did not answer with an ok result");

  a_reject_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == KIND_END && key_bad) |=> (out_valid_r && out_status_r))
    else $error("bad key was not rejected");

endmodule

/* src/ksc_key_store.sv */
// Pending key storage: first-seen letter order, used-letter mask, fill count and bad flag.
// One insert unit serves both key letters and the alphabet-order fill walk.
// Depends on ksc_pkg.
module ksc_key_store
  import ksc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ksc_ctl_t         ctl,
  output logic [IDX_W-1:0] pend_rd,
  output logic [CNT_W-1:0] pend_cnt,
  output logic             key_bad
);

  logic [IDX_W-1:0] pend_r [ALPHA_N];
  logic [ALPHA_N-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic bad_r, bad_nxt;
  logic ins_req, ins_go;
  logic [IDX_W-1:0] ins_idx;

  // A letter is inserted only if it is unused and the permutation still has room.
  always_comb begin
    ins_req = (ctl.key_letter && ctl.letter_ok) || ctl.fill_step;
    ins_idx = ctl.fill_step ? ctl.walk_idx : ctl.letter_idx;
    ins_go  = ins_req && !used_r[ins_idx] && (cnt_r < CNT_W'(ALPHA_N));
  end

  always_comb begin
    used_nxt = used_r;
    cnt_nxt  = cnt_r;
    bad_nxt  = bad_r;
    if (ctl.clear) begin
      used_nxt = '0;
      cnt_nxt  = '0;
      bad_nxt  = 1'b0;
    end else begin
      if (ctl.key_letter && !ctl.letter_ok) begin
        bad_nxt = 1'b1;
      end
      if (ins_go) begin
        used_nxt[ins_idx] = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      cnt_r  <= '0;
      bad_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      cnt_r  <= cnt_nxt;
      bad_r  <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_go && !ctl.clear) begin
      pend_r[cnt_r[IDX_W-1:0]] <= ins_idx;
    end
  end

  assign pend_rd  = pend_r[ctl.walk_idx];
  assign pend_cnt = cnt_r;
  assign key_bad  = bad_r;

endmodule

/* src/ksc_map_table.sv */
// Active forward and inverse substitution tables, reset to the identity mapping.
// Loaded one entry per cycle from the pending key during installation.
// Depends on ksc_pkg.
module ksc_map_table
  import ksc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ksc_ctl_t         ctl,
  input  logic [IDX_W-1:0] pend_rd,
  input  logic [IDX_W-1:0] look_idx,
  input  logic             look_inv,
  output logic [IDX_W-1:0] look_map
);

  logic [IDX_W-1:0] fwd_r [ALPHA_N];
  logic [IDX_W-1:0] inv_r [ALPHA_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHA_N; i++) begin
        fwd_r[i] <= IDX_W'(i);
        inv_r[i] <= IDX_W'(i);
      end
    end else if (ctl.copy_step) begin
      fwd_r[ctl.walk_idx] <= pend_rd;
      inv_r[pend_rd]      <= ctl.walk_idx;
    end
  end

  assign look_map = look_inv ? inv_r[look_idx] : fwd_r[look_idx];

endmodule
